// ===== rtl/core/dfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpa_pkg: shared types and constants of the decimal fixed-point ALU
// Operation codes, field widths and the sideband that rides the divider.
// ----------------------------------------------------------------------------
package dfpa_pkg;

  localparam int unsigned VAL_W  = 51;          // operand and result width
  localparam int unsigned MAG_W  = 51;          // magnitude of an operand
  localparam int unsigned QUO_W  = 50;          // quotient bits; results stay below 2^50
  localparam int unsigned NUM_W  = 2 * MAG_W;   // product or scaled dividend
  localparam int unsigned LO_W   = 26;          // low half of a split operand
  localparam int unsigned HI_W   = MAG_W - LO_W;
  localparam int unsigned OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PASS = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  // Travels alongside the divider: result of the short operations, or the
  // sign to apply to the quotient for multiply and divide.
  typedef struct packed {
    logic             md;    // multiply or divide, take the quotient
    logic             neg;   // quotient sign
    logic             err;   // error of the short operations
    logic [VAL_W-1:0] res;   // result of the short operations
  } side_t;

endpackage

// ===== rtl/core/dfpa_divider.sv =====
// ----------------------------------------------------------------------------
// dfpa_divider: pipelined restoring divider
// One quotient bit per stage; flags a quotient that needs more than QUO_W bits.
// ----------------------------------------------------------------------------
module dfpa_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [dfpa_pkg::NUM_W-1:0]     num_i,
  input  logic [dfpa_pkg::MAG_W-1:0]     den_i,
  input  dfpa_pkg::side_t                side_i,
  output logic                           valid_o,
  output logic [dfpa_pkg::QUO_W-1:0]     quo_o,
  output logic                           ovf_o,
  output dfpa_pkg::side_t                side_o
);

  localparam int unsigned QW = dfpa_pkg::QUO_W;
  localparam int unsigned MW = dfpa_pkg::MAG_W;
  localparam int unsigned NW = dfpa_pkg::NUM_W;

  logic [QW:0]           vld_q;
  logic [MW-1:0]         rem_q  [QW+1];
  logic [QW-1:0]         nlo_q  [QW+1];
  logic [QW-1:0]         quo_q  [QW+1];
  logic [MW-1:0]         den_q  [QW+1];
  logic [QW:0]           ovf_q;
  dfpa_pkg::side_t       side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  // Entry: the upper part of the numerator must stay below the divisor,
  // otherwise the quotient does not fit (also catches a zero divisor).
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i[NW-2 -: MW];
    nlo_q[0]  <= num_i[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    ovf_q[0]  <= (num_i[NW-1 -: MW+1] >= {1'b0, den_i});
    side_q[0] <= side_i;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [MW:0] trial;
    logic        ge;

    assign trial = {rem_q[i-1], nlo_q[i-1][QW-1]};
    assign ge    = (trial >= {1'b0, den_q[i-1]});

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? MW'(trial - {1'b0, den_q[i-1]}) : trial[MW-1:0];
      nlo_q[i]  <= {nlo_q[i-1][QW-2:0], 1'b0};
      quo_q[i]  <= {quo_q[i-1][QW-2:0], ge};
      den_q[i]  <= den_q[i-1];
      ovf_q[i]  <= ovf_q[i-1];
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== rtl/core/decimal_fixed_point_alu_core.sv =====
// Path: an accepted request passes stages A, B and C, the divider and the output register to its done_o strobe.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// The restoring divider holds 50 stages, one quotient bit per stage.
// Reset: rst_ni clears all valid bits asynchronously; no result strobes after reset.
// Results appear once, on done_o, and the receiver cannot hold them off.
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu_core: signed decimal fixed-point ALU
// Pass, add, subtract, multiply and divide on values scaled by 10^FRAC_DIGITS.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu_core #(
  parameter int unsigned FRAC_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [dfpa_pkg::OP_W-1:0]        operation_i,
  input  logic signed [dfpa_pkg::VAL_W-1:0] lhs_i,
  input  logic signed [dfpa_pkg::VAL_W-1:0] rhs_i,
  output logic                             done_o,
  output logic signed [dfpa_pkg::VAL_W-1:0] result_o,
  output logic                             error_o
);

  localparam int unsigned VW = dfpa_pkg::VAL_W;
  localparam int unsigned MW = dfpa_pkg::MAG_W;
  localparam int unsigned QW = dfpa_pkg::QUO_W;
  localparam int unsigned NW = dfpa_pkg::NUM_W;
  localparam int unsigned LW = dfpa_pkg::LO_W;
  localparam int unsigned HW = dfpa_pkg::HI_W;
  localparam int unsigned LAT = 5 + QW;

  // Scale, limit and the largest magnitude that is reported without error.
  localparam logic [63:0] SCALE  = 64'd10 ** FRAC_DIGITS;
  localparam logic [63:0] LIMIT  = 64'd999999999 * SCALE;
  localparam logic [63:0] QMAX   = (64'd1 << QW) - 64'd1;
  localparam logic [63:0] MAXMAG = (LIMIT < QMAX) ? LIMIT : QMAX;

  // --------------------------------------------------------------------------
  // Stage A: register magnitudes, sign and the sum or difference
  // --------------------------------------------------------------------------
  logic          acc;
  logic          a_vld_q;
  logic [MW-1:0] a_maga_q, a_magb_q;
  logic          a_neg_q, a_md_q, a_div_q, a_short_q;
  logic [VW:0]   a_sum_q;
  logic [VW-1:0] a_rhs_q;

  logic          dec_md, dec_div, dec_short, dec_sub;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_comb begin
    dec_md    = 1'b0;
    dec_div   = 1'b0;
    dec_short = 1'b0;
    dec_sub   = 1'b0;
    unique case (operation_i)
      dfpa_pkg::OP_ADD: begin
        dec_short = 1'b1;
      end
      dfpa_pkg::OP_SUB: begin
        dec_short = 1'b1;
        dec_sub   = 1'b1;
      end
      dfpa_pkg::OP_MUL: begin
        dec_md = 1'b1;
      end
      dfpa_pkg::OP_DIV: begin
        dec_md  = 1'b1;
        dec_div = 1'b1;
      end
      default: begin
        // pass and the spare codes: hand rhs through untouched
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a_maga_q  <= lhs_i[VW-1] ? MW'(~lhs_i + 1'b1) : MW'(lhs_i);
    a_magb_q  <= rhs_i[VW-1] ? MW'(~rhs_i + 1'b1) : MW'(rhs_i);
    a_neg_q   <= lhs_i[VW-1] ^ rhs_i[VW-1];
    a_md_q    <= dec_md;
    a_div_q   <= dec_div;
    a_short_q <= dec_short;
    a_sum_q   <= dec_sub ? ({lhs_i[VW-1], lhs_i} - {rhs_i[VW-1], rhs_i})
                         : ({lhs_i[VW-1], lhs_i} + {rhs_i[VW-1], rhs_i});
    a_rhs_q   <= rhs_i;
  end

  // --------------------------------------------------------------------------
  // Stage B: partial products of |lhs| * x and range check of the sum.
  // Multiply divides |lhs|*|rhs| by the scale; divide divides |lhs|*scale by
  // |rhs|, so one product and one divider serve both.
  // --------------------------------------------------------------------------
  logic [MW-1:0]      b_x, b_den;
  logic signed [63:0] b_sum_s;
  logic               b_sum_err;

  logic               b_vld_q;
  logic [2*LW-1:0]    b_ll_q;
  logic [LW+HW-1:0]   b_lh_q, b_hl_q;
  logic [2*HW-1:0]    b_hh_q;
  logic [MW-1:0]      b_den_q;
  dfpa_pkg::side_t    b_side_q;

  assign b_x       = a_div_q ? MW'(SCALE) : a_magb_q;
  assign b_den     = a_div_q ? a_magb_q : MW'(SCALE);
  assign b_sum_s   = 64'($signed(a_sum_q));
  assign b_sum_err = (b_sum_s > $signed(MAXMAG)) || (b_sum_s < -$signed(MAXMAG));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ll_q       <= a_maga_q[LW-1:0]     * b_x[LW-1:0];
    b_lh_q       <= a_maga_q[LW-1:0]     * b_x[MW-1 -: HW];
    b_hl_q       <= a_maga_q[MW-1 -: HW] * b_x[LW-1:0];
    b_hh_q       <= a_maga_q[MW-1 -: HW] * b_x[MW-1 -: HW];
    b_den_q      <= b_den;
    b_side_q.md  <= a_md_q;
    b_side_q.neg <= a_neg_q;
    b_side_q.err <= a_short_q && b_sum_err;
    // pass reports rhs as it is; add and subtract report zero on error
    if (a_short_q) begin
      b_side_q.res <= b_sum_err ? '0 : a_sum_q[VW-1:0];
    end else begin
      b_side_q.res <= a_rhs_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: add the partial products into the full numerator
  // --------------------------------------------------------------------------
  logic            c_vld_q;
  logic [NW-1:0]   c_num_q;
  logic [MW-1:0]   c_den_q;
  dfpa_pkg::side_t c_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_num_q  <= NW'(b_ll_q)
              + (NW'(b_lh_q) << LW)
              + (NW'(b_hl_q) << LW)
              + (NW'(b_hh_q) << (2 * LW));
    c_den_q  <= b_den_q;
    c_side_q <= b_side_q;
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage
  // --------------------------------------------------------------------------
  logic            d_vld;
  logic [QW-1:0]   d_quo;
  logic            d_ovf;
  dfpa_pkg::side_t d_side;

  dfpa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .num_i   (c_num_q),
    .den_i   (c_den_q),
    .side_i  (c_side_q),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .ovf_o   (d_ovf),
    .side_o  (d_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: range check, sign and selection of the result
  // --------------------------------------------------------------------------
  logic          o_err;
  logic [VW-1:0] o_qx, o_res;

  logic          done_q, error_q;
  logic [VW-1:0] result_q;

  assign o_qx = VW'(d_quo);

  always_comb begin
    if (d_side.md) begin
      o_err = d_ovf || (64'(d_quo) > MAXMAG);
      if (o_err) begin
        o_res = '0;
      end else begin
        o_res = d_side.neg ? VW'(~o_qx + 1'b1) : o_qx;
      end
    end else begin
      o_err = d_side.err;
      o_res = d_side.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= o_res;
    error_q  <= o_err;
  end

  assign done_o   = done_q;
  assign result_o = result_q;
  assign error_o  = error_q;

`ifndef SYNTHESIS
  // an error result always reads as zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_o |-> result_o == '0)
    else $error("error result is not zero");

  // every request comes out after the fixed latency
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("request lost in the pipeline");

  // no strobe without a request
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> ##LAT !done_o)
    else $error("result without request");
`endif

endmodule
